// File: sv/fqmq_pkg.sv
package fqmq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned STATUS_W = 2;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic clr;
    logic dv;
  } scan_ctl_t;

endpackage

// File: sv/fifo_queue_with_max_query.sv
// Flow: a beat is taken only in idle, and no new beat is taken before the result of the
// last one has been loaded into the output register. The maximum scan reads one ring
// entry per cycle through the single read port of the ring memory.
// Reset: synchronous, active low; clears head, count, sequencer and output valid. Ring
// contents stay undefined and need no clearing.
module fifo_queue_with_max_query #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_op,
  input  logic signed [fqmq_pkg::DATA_W-1:0]    in_push_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [fqmq_pkg::STATUS_W-1:0]         out_status,
  output logic signed [fqmq_pkg::DATA_W-1:0]    out_popped_value,
  output logic [$clog2(DEPTH+1)-1:0]            out_entry_count,
  output logic                                  out_is_empty,
  output logic signed [fqmq_pkg::DATA_W-1:0]    out_largest_value,
  output logic [$clog2(DEPTH+1)-1:0]            out_largest_position
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [AW:0]        DEPTH_A = (AW+1)'(DEPTH);
  localparam logic [CNT_W-1:0]   DEPTH_C = CNT_W'(DEPTH);
  localparam logic [AW-1:0]      LAST_IDX = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [AW-1:0]    head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] scan_pos_r, scan_pos_nxt;
  logic             scan_dv_r, scan_dv_nxt;
  logic             pop_dv_r, pop_dv_nxt;
  logic [fqmq_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic signed [fqmq_pkg::DATA_W-1:0] popped_r, popped_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [fqmq_pkg::STATUS_W-1:0] out_status_r;
  logic signed [fqmq_pkg::DATA_W-1:0] out_popped_r, out_largest_r;
  logic [CNT_W-1:0]              out_count_r, out_pos_r;

  logic            accept, load_out;
  logic [AW-1:0]   offset;
  logic [AW:0]     addr_sum;
  logic [AW-1:0]   addr_wrap;

  logic            wr_en, rd_en;
  logic [AW-1:0]   rd_addr;
  logic signed [fqmq_pkg::DATA_W-1:0] rd_data;

  fqmq_pkg::scan_ctl_t                scan_ctl;
  logic signed [fqmq_pkg::DATA_W-1:0] best;
  logic [CNT_W-1:0]                   best_pos;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // shared ring address adder: tail on accept, scan entry otherwise
  assign offset    = (state_r == S_IDLE) ? count_r[AW-1:0] : k_r[AW-1:0];
  assign addr_sum  = {1'b0, head_r} + {1'b0, offset};
  assign addr_wrap = (addr_sum >= DEPTH_A) ? AW'(addr_sum - DEPTH_A) : addr_sum[AW-1:0];

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    k_nxt        = k_r;
    scan_pos_nxt = scan_pos_r;
    scan_dv_nxt  = 1'b0;
    pop_dv_nxt   = 1'b0;
    status_nxt   = status_r;
    popped_nxt   = popped_r;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = addr_wrap;
    scan_ctl.clr = 1'b0;
    scan_ctl.dv  = scan_dv_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          scan_ctl.clr = 1'b1;
          status_nxt   = fqmq_pkg::STATUS_OK;
          popped_nxt   = '0;
          k_nxt        = '0;
          state_nxt    = S_SCAN;
          if (in_op == fqmq_pkg::OP_PUSH) begin
            if (count_r == DEPTH_C) begin
              status_nxt = fqmq_pkg::STATUS_FULL;
            end else begin
              wr_en     = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = fqmq_pkg::STATUS_EMPTY;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = head_r;
              pop_dv_nxt = 1'b1;
              head_nxt   = (head_r == LAST_IDX) ? '0 : head_r + AW'(1);
              count_nxt  = count_r - CNT_W'(1);
            end
          end
        end
      end
      S_SCAN: begin
        if (pop_dv_r) begin
          popped_nxt = rd_data;
        end
        if (k_r < count_r) begin
          rd_en        = 1'b1;
          scan_dv_nxt  = 1'b1;
          scan_pos_nxt = k_r;
          k_nxt        = k_r + CNT_W'(1);
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      scan_dv_r   <= 1'b0;
      pop_dv_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      scan_dv_r   <= scan_dv_nxt;
      pop_dv_r    <= pop_dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    scan_pos_r <= scan_pos_nxt;
    status_r   <= status_nxt;
    popped_r   <= popped_nxt;
    if (load_out) begin
      out_status_r  <= status_r;
      out_popped_r  <= popped_r;
      out_count_r   <= count_r;
      out_largest_r <= best;
      out_pos_r     <= best_pos;
    end
  end

  fqmq_ram #(
    .WIDTH (fqmq_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (addr_wrap),
    .wr_data (in_push_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  fqmq_maxcmp #(
    .CNT_W (CNT_W)
  ) u_maxcmp (
    .clk      (clk),
    .ctl      (scan_ctl),
    .pos      (scan_pos_r),
    .data     (rd_data),
    .best     (best),
    .best_pos (best_pos)
  );

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_popped_value     = out_popped_r;
  assign out_entry_count      = out_count_r;
  assign out_is_empty         = (out_count_r == '0);
  assign out_largest_value    = out_largest_r;
  assign out_largest_position = out_pos_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("stored count beyond depth");

  a_full_push_drop: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_op == fqmq_pkg::OP_PUSH) && (count_r == DEPTH_C) |=> count_r == DEPTH_C)
    else $error("push on full queue changed the count");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r && (state_r == S_IDLE))
    else $error("finished result not presented");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_pos_r <= out_count_r)
    else $error("largest position beyond entry count");

  a_empty_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_count_r != '0) |-> out_pos_r != '0)
    else $error("non-empty queue without a largest position");

endmodule

// File: sv/fqmq_ram.sv
module fqmq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/fqmq_maxcmp.sv
module fqmq_maxcmp #(
  parameter int unsigned CNT_W = 5
) (
  input  logic                             clk,
  input  fqmq_pkg::scan_ctl_t              ctl,
  input  logic [CNT_W-1:0]                 pos,
  input  logic signed [fqmq_pkg::DATA_W-1:0] data,
  output logic signed [fqmq_pkg::DATA_W-1:0] best,
  output logic [CNT_W-1:0]                 best_pos
);

  logic signed [fqmq_pkg::DATA_W-1:0] best_r, best_nxt;
  logic [CNT_W-1:0]                   best_pos_r, best_pos_nxt;
  logic                               take;

  assign take = ctl.dv && ((pos == '0) || (data > best_r));

  always_comb begin
    best_nxt     = best_r;
    best_pos_nxt = best_pos_r;
    if (ctl.clr) begin
      best_nxt     = '0;
      best_pos_nxt = '0;
    end else if (take) begin
      best_nxt     = data;
      best_pos_nxt = pos + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    best_r     <= best_nxt;
    best_pos_r <= best_pos_nxt;
  end

  assign best     = best_r;
  assign best_pos = best_pos_r;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned QDEPTH = 16;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);
  localparam int unsigned RANDOM_BEATS = 500;
  localparam logic signed [fqmq_pkg::DATA_W-1:0] VMAX = 32'sh7FFF_FFFF;
  localparam logic signed [fqmq_pkg::DATA_W-1:0] VMIN = 32'sh8000_0000;

  typedef struct packed {
    logic [fqmq_pkg::STATUS_W-1:0]      status;
    logic signed [fqmq_pkg::DATA_W-1:0] popped;
    logic [CNT_W-1:0]                   count;
    logic                               empty;
    logic signed [fqmq_pkg::DATA_W-1:0] largest;
    logic [CNT_W-1:0]                   position;
  } queue_result_t;

  typedef struct {
    logic                               op;
    logic signed [fqmq_pkg::DATA_W-1:0] value;
    bit                                 pinned;
    queue_result_t                      res;
  } stim_row_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic                               in_op = fqmq_pkg::OP_PUSH;
  logic signed [fqmq_pkg::DATA_W-1:0] in_push_value = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic [fqmq_pkg::STATUS_W-1:0]      out_status;
  logic signed [fqmq_pkg::DATA_W-1:0] out_popped_value;
  logic [CNT_W-1:0]                   out_entry_count;
  logic                               out_is_empty;
  logic signed [fqmq_pkg::DATA_W-1:0] out_largest_value;
  logic [CNT_W-1:0]                   out_largest_position;

  logic signed [fqmq_pkg::DATA_W-1:0] model_ring [QDEPTH];
  int unsigned                        model_head = 0;
  int unsigned                        model_count = 0;

  queue_result_t awaited_results [$];
  queue_result_t predicted;
  queue_result_t oldest;
  queue_result_t pinned_result = '0;
  bit            beat_pinned = 1'b0;
  bit            sender_calm = 1'b0;
  int            mismatch_count = 0;
  stim_row_t     directed_rows [$];

  fifo_queue_with_max_query #(
    .DEPTH(QDEPTH)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_op               (in_op),
    .in_push_value       (in_push_value),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_popped_value    (out_popped_value),
    .out_entry_count     (out_entry_count),
    .out_is_empty        (out_is_empty),
    .out_largest_value   (out_largest_value),
    .out_largest_position(out_largest_position)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic queue_result_t apply_queue_op(
      input logic op, input logic signed [fqmq_pkg::DATA_W-1:0] value);
    queue_result_t                      r;
    logic signed [fqmq_pkg::DATA_W-1:0] v;
    int unsigned                        k;
    r = '0;
    r.status = fqmq_pkg::STATUS_OK;
    if (op == fqmq_pkg::OP_PUSH) begin
      if (model_count >= QDEPTH) begin
        r.status = fqmq_pkg::STATUS_FULL;
      end else begin
        model_ring[(model_head + model_count) % QDEPTH] = value;
        model_count++;
      end
    end else begin
      if (model_count == 0) begin
        r.status = fqmq_pkg::STATUS_EMPTY;
      end else begin
        r.popped = model_ring[model_head];
        model_head = (model_head + 1) % QDEPTH;
        model_count--;
      end
    end
    for (k = 0; k < model_count; k++) begin
      v = model_ring[(model_head + k) % QDEPTH];
      if (k == 0 || v > r.largest) begin
        r.largest = v;
        r.position = CNT_W'(k + 1);
      end
    end
    r.count = CNT_W'(model_count);
    r.empty = (model_count == 0);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [fqmq_pkg::DATA_W-1:0] exp_v,
                             input logic [fqmq_pkg::DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: out_%s mismatch, expected 0x%08h, got 0x%08h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predicted = apply_queue_op(in_op, in_push_value);
        if (beat_pinned) begin
          predicted = pinned_result;
        end
        awaited_results.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got status %0d", $time,
                   out_status);
          mismatch_count++;
        end else begin
          oldest = awaited_results.pop_front();
          check_field("status", fqmq_pkg::DATA_W'(oldest.status),
                      fqmq_pkg::DATA_W'(out_status));
          check_field("popped_value", oldest.popped, out_popped_value);
          check_field("entry_count", fqmq_pkg::DATA_W'(oldest.count),
                      fqmq_pkg::DATA_W'(out_entry_count));
          check_field("is_empty", fqmq_pkg::DATA_W'(oldest.empty),
                      fqmq_pkg::DATA_W'(out_is_empty));
          check_field("largest_value", oldest.largest, out_largest_value);
          check_field("largest_position", fqmq_pkg::DATA_W'(oldest.position),
                      fqmq_pkg::DATA_W'(out_largest_position));
        end
      end
    end
  end

  task automatic send_beat(input logic op, input logic signed [fqmq_pkg::DATA_W-1:0] value,
                           input bit pinned, input queue_result_t res);
    @(negedge clk);
    if (!sender_calm) begin
      while ($urandom_range(0, 99) < 19) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_push_value <= value;
    beat_pinned <= pinned;
    pinned_result <= res;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic add_row(input logic op, input logic signed [fqmq_pkg::DATA_W-1:0] value);
    stim_row_t row;
    row.op = op;
    row.value = value;
    row.pinned = 1'b0;
    row.res = '0;
    directed_rows.push_back(row);
  endtask

  task automatic pin_last(input logic [fqmq_pkg::STATUS_W-1:0] status,
                          input logic signed [fqmq_pkg::DATA_W-1:0] popped,
                          input int unsigned count, input logic empty,
                          input logic signed [fqmq_pkg::DATA_W-1:0] largest,
                          input int unsigned position);
    stim_row_t row;
    row = directed_rows.pop_back();
    row.pinned = 1'b1;
    row.res.status = status;
    row.res.popped = popped;
    row.res.count = CNT_W'(count);
    row.res.empty = empty;
    row.res.largest = largest;
    row.res.position = CNT_W'(position);
    directed_rows.push_back(row);
  endtask

  function automatic logic signed [fqmq_pkg::DATA_W-1:0] random_value();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 8) - 4;
      1:       return $urandom_range(0, 1) ? VMAX : VMIN;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned mode;
    logic        op;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    add_row(fqmq_pkg::OP_POP, 0);
    pin_last(fqmq_pkg::STATUS_EMPTY, 0, 0, 1'b1, 0, 0);
    add_row(fqmq_pkg::OP_PUSH, VMAX);
    pin_last(fqmq_pkg::STATUS_OK, 0, 1, 1'b0, VMAX, 1);
    add_row(fqmq_pkg::OP_PUSH, VMIN);
    pin_last(fqmq_pkg::STATUS_OK, 0, 2, 1'b0, VMAX, 1);
    add_row(fqmq_pkg::OP_POP, -1);
    pin_last(fqmq_pkg::STATUS_OK, VMAX, 1, 1'b0, VMIN, 1);
    add_row(fqmq_pkg::OP_POP, VMAX);
    pin_last(fqmq_pkg::STATUS_OK, VMIN, 0, 1'b1, 0, 0);
    add_row(fqmq_pkg::OP_POP, VMIN);
    pin_last(fqmq_pkg::STATUS_EMPTY, 0, 0, 1'b1, 0, 0);
    add_row(fqmq_pkg::OP_PUSH, VMIN);
    pin_last(fqmq_pkg::STATUS_OK, 0, 1, 1'b0, VMIN, 1);
    add_row(fqmq_pkg::OP_PUSH, -1);
    add_row(fqmq_pkg::OP_PUSH, 1);
    add_row(fqmq_pkg::OP_PUSH, VMAX);
    add_row(fqmq_pkg::OP_PUSH, 0);
    add_row(fqmq_pkg::OP_PUSH, VMAX);
    add_row(fqmq_pkg::OP_PUSH, 2);
    add_row(fqmq_pkg::OP_PUSH, -2);
    add_row(fqmq_pkg::OP_PUSH, 3);
    add_row(fqmq_pkg::OP_PUSH, VMIN);
    add_row(fqmq_pkg::OP_PUSH, 100);
    add_row(fqmq_pkg::OP_PUSH, -100);
    add_row(fqmq_pkg::OP_PUSH, 7);
    add_row(fqmq_pkg::OP_PUSH, 7);
    add_row(fqmq_pkg::OP_PUSH, VMAX);
    add_row(fqmq_pkg::OP_PUSH, 9);
    add_row(fqmq_pkg::OP_PUSH, 42);
    pin_last(fqmq_pkg::STATUS_FULL, 0, 16, 1'b0, VMAX, 4);
    add_row(fqmq_pkg::OP_POP, 0);
    add_row(fqmq_pkg::OP_PUSH, 5);

    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].op, directed_rows[i].value, directed_rows[i].pinned,
                directed_rows[i].res);
    end

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == 250) begin
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(negedge clk);
      end
      sender_calm = (i >= 300 && i < 400);
      mode = (i / 40) % 3;
      case (mode)
        0:       op = ($urandom_range(0, 99) < 75) ? fqmq_pkg::OP_PUSH : fqmq_pkg::OP_POP;
        1:       op = ($urandom_range(0, 99) < 75) ? fqmq_pkg::OP_POP : fqmq_pkg::OP_PUSH;
        default: op = $urandom_range(0, 1) ? fqmq_pkg::OP_POP : fqmq_pkg::OP_PUSH;
      endcase
      send_beat(op, random_value(), 1'b0, '0);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (QDEPTH + 4) @(posedge clk);

    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("[fifo_queue_with_max_query] OK");
    end else begin
      $display("[fifo_queue_with_max_query] ERROR");
    end
    $finish;
  end

  initial begin
    int unsigned rx_cycle;
    rx_cycle = 0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle >= 2000 && rx_cycle < 2200) begin
        out_ready <= 1'b0;
      end else if (rx_cycle >= 5000 && rx_cycle < 6500) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 19);
      end
    end
  end

  initial begin
    #400000;
    $display("[fifo_queue_with_max_query] ERROR");
    $finish;
  end

endmodule
